FILE: src/i2cstb_pkg.sv
// Shared types and constants for the I2C slave transfer buffer.
// Holds the bus event codes, the transfer structs and the RAM request struct.
// No dependencies.
`timescale 1ns / 1ps

package i2cstb_pkg;

  typedef enum logic [3:0] {
    MODE_READ_ADDR  = 4'd0,
    MODE_REPLY_ACK  = 4'd1,
    MODE_REPLY_DONE = 4'd2,
    MODE_WRITE_ADDR = 4'd3,
    MODE_BYTE_RX    = 4'd4,
    MODE_STOP       = 4'd5,
    MODE_OTHER      = 4'd6,
    MODE_LOAD_BYTE  = 4'd7,
    MODE_SET_LEN    = 4'd8
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_REPLY,
    ST_BUS_REPLY,
    ST_STOP_CMD,
    ST_STOP_ZERO,
    ST_STOP_DATA
  } state_e;

  localparam logic KIND_BUS = 1'b0;
  localparam logic KIND_MSG = 1'b1;

  localparam logic [5:0] INDEX_MAX = 6'd63;
  localparam int unsigned MSG_MAX = 16;

  typedef struct packed {
    logic [3:0] mode;
    logic [7:0] data_byte;
    logic [3:0] load_slot;
    logic [4:0] load_length;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] reply_byte;
    logic       ack_next;
    logic [7:0] command;
    logic [7:0] payload_byte;
    logic [3:0] payload_pos;
    logic [4:0] payload_length;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic       we;
    logic [5:0] waddr;
    logic [7:0] wdata;
    logic       re;
    logic [5:0] raddr;
  } ram_req_t;

endpackage

FILE: src/i2cstb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module i2cstb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/i2cstb_seq.sv
// Event sequencer: decodes bus events, drives the reply and receive RAMs and
// walks the receive RAM on a stop. Depends on i2cstb_pkg.
`timescale 1ns / 1ps

module i2cstb_seq #(
  parameter int unsigned RX_DEPTH = 16,
  parameter int unsigned TX_DEPTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  i2cstb_pkg::in_item_t   in_item_i,
  output logic                   res_valid_o,
  input  logic                   res_stall_i,
  output i2cstb_pkg::out_item_t  res_o,
  output i2cstb_pkg::ram_req_t   tx_req_o,
  input  logic [7:0]             tx_rdata_i,
  output i2cstb_pkg::ram_req_t   rx_req_o,
  input  logic [7:0]             rx_rdata_i
);
  import i2cstb_pkg::*;

  localparam int unsigned RX_WORDS = RX_DEPTH + 1;
  localparam int unsigned TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int unsigned RX_AW = (RX_WORDS > 1) ? $clog2(RX_WORDS) : 1;
  localparam int unsigned PLEN_CAP = (RX_DEPTH < MSG_MAX) ? RX_DEPTH : MSG_MAX;
  localparam logic [6:0] TX_LIMIT = 7'(TX_DEPTH);
  localparam logic [6:0] RX_LIMIT = 7'(RX_WORDS);
  localparam logic [5:0] PLEN_LIMIT = 6'(PLEN_CAP);

  state_e               state_q, state_d;
  logic [5:0]           idx_q, idx_d;
  logic [4:0]           rlen_q, rlen_d;
  logic [TX_DEPTH-1:0]  tx_vld_q, tx_vld_d;
  logic [RX_WORDS-1:0]  rx_vld_q, rx_vld_d;
  logic [4:0]           plen_q, plen_d;
  logic [3:0]           pos_q, pos_d;
  logic [7:0]           cmd_q, cmd_d;
  logic                 ack_q, ack_d;
  logic                 hit_q, hit_d;

  logic       accept;
  logic       res_adv;
  logic       msg_last;
  logic [5:0] idx_inc;
  logic [5:0] rd_idx;
  logic [5:0] rd_next;
  logic [5:0] plen_raw;
  logic [5:0] plen_cap;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept   = in_valid_i && !in_stall_o;
  assign res_adv  = res_valid_o && !res_stall_i;
  assign msg_last = (5'({1'b0, pos_q}) + 5'd1) == plen_q;
  assign idx_inc  = (idx_q == INDEX_MAX) ? idx_q : idx_q + 6'd1;
  assign rd_idx   = (in_item_i.mode == MODE_READ_ADDR) ? 6'd0 : idx_q;
  assign rd_next  = (rd_idx == INDEX_MAX) ? rd_idx : rd_idx + 6'd1;
  assign plen_raw = idx_q - 6'd1;
  assign plen_cap = (plen_raw > PLEN_LIMIT) ? PLEN_LIMIT : plen_raw;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_item_i.mode)
            MODE_READ_ADDR, MODE_REPLY_ACK: state_d = ST_RD_REPLY;
            MODE_STOP: state_d = (idx_q == 6'd0) ? ST_BUS_REPLY : ST_STOP_CMD;
            MODE_LOAD_BYTE, MODE_SET_LEN: state_d = ST_IDLE;
            default: state_d = ST_BUS_REPLY;
          endcase
        end
      end
      ST_RD_REPLY, ST_BUS_REPLY, ST_STOP_ZERO: begin
        if (res_adv) begin
          state_d = ST_IDLE;
        end
      end
      ST_STOP_CMD: state_d = (plen_q == 5'd0) ? ST_STOP_ZERO : ST_STOP_DATA;
      ST_STOP_DATA: begin
        if (res_adv && msg_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;
    tx_req_o    = '0;
    rx_req_o    = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_item_i.mode)
            MODE_READ_ADDR, MODE_REPLY_ACK: begin
              tx_req_o.re    = 1'b1;
              tx_req_o.raddr = rd_idx;
            end
            MODE_BYTE_RX: begin
              rx_req_o.we    = {1'b0, idx_q} < RX_LIMIT;
              rx_req_o.waddr = idx_q;
              rx_req_o.wdata = in_item_i.data_byte;
            end
            MODE_STOP: begin
              rx_req_o.re    = (idx_q != 6'd0);
              rx_req_o.raddr = 6'd0;
            end
            MODE_LOAD_BYTE: begin
              tx_req_o.we    = {3'b000, in_item_i.load_slot} < TX_LIMIT;
              tx_req_o.waddr = {2'b00, in_item_i.load_slot};
              tx_req_o.wdata = in_item_i.data_byte;
            end
            default: ;
          endcase
        end
      end
      ST_RD_REPLY: begin
        res_valid_o      = 1'b1;
        res_o.kind       = KIND_BUS;
        res_o.reply_byte = hit_q ? tx_rdata_i : 8'd0;
        res_o.ack_next   = ack_q;
        res_o.last       = 1'b1;
      end
      ST_BUS_REPLY: begin
        res_valid_o    = 1'b1;
        res_o.kind     = KIND_BUS;
        res_o.ack_next = ack_q;
        res_o.last     = 1'b1;
      end
      ST_STOP_CMD: begin
        rx_req_o.re    = (plen_q != 5'd0);
        rx_req_o.raddr = 6'd1;
      end
      ST_STOP_ZERO: begin
        res_valid_o    = 1'b1;
        res_o.kind     = KIND_MSG;
        res_o.ack_next = 1'b1;
        res_o.command  = cmd_q;
        res_o.last     = 1'b1;
      end
      ST_STOP_DATA: begin
        res_valid_o          = 1'b1;
        res_o.kind           = KIND_MSG;
        res_o.ack_next       = 1'b1;
        res_o.command        = cmd_q;
        res_o.payload_byte   = hit_q ? rx_rdata_i : 8'd0;
        res_o.payload_pos    = pos_q;
        res_o.payload_length = plen_q;
        res_o.last           = msg_last;
        rx_req_o.re          = res_adv && !msg_last;
        rx_req_o.raddr       = {2'b00, pos_q} + 6'd2;
      end
      default: ;
    endcase
  end

  always_comb begin
    idx_d    = idx_q;
    rlen_d   = rlen_q;
    tx_vld_d = tx_vld_q;
    rx_vld_d = rx_vld_q;
    plen_d   = plen_q;
    pos_d    = pos_q;
    cmd_d    = cmd_q;
    ack_d    = ack_q;
    hit_d    = hit_q;

    if (tx_req_o.re) begin
      hit_d = ({1'b0, tx_req_o.raddr} < TX_LIMIT) && tx_vld_q[tx_req_o.raddr[TX_AW-1:0]];
    end else if (rx_req_o.re) begin
      hit_d = rx_vld_q[rx_req_o.raddr[RX_AW-1:0]];
    end
    if (tx_req_o.we) begin
      tx_vld_d[tx_req_o.waddr[TX_AW-1:0]] = 1'b1;
    end
    if (rx_req_o.we) begin
      rx_vld_d[rx_req_o.waddr[RX_AW-1:0]] = 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_item_i.mode)
            MODE_READ_ADDR, MODE_REPLY_ACK: begin
              idx_d = rd_next;
              ack_d = rd_next < {1'b0, rlen_q};
            end
            MODE_WRITE_ADDR: begin
              idx_d = 6'd0;
              ack_d = (RX_DEPTH != 0);
            end
            MODE_BYTE_RX: begin
              idx_d = idx_inc;
              ack_d = {1'b0, idx_inc} < RX_LIMIT;
            end
            MODE_STOP: begin
              ack_d  = 1'b1;
              plen_d = plen_cap[4:0];
            end
            MODE_SET_LEN: begin
              rlen_d = ({2'b00, in_item_i.load_length} > TX_LIMIT) ? TX_LIMIT[4:0]
                                                                    : in_item_i.load_length;
            end
            MODE_LOAD_BYTE: ;
            default: ack_d = 1'b1;
          endcase
        end
      end
      ST_STOP_CMD: begin
        cmd_d = hit_q ? rx_rdata_i : 8'd0;
        pos_d = 4'd0;
      end
      ST_STOP_DATA: begin
        if (res_adv && !msg_last) begin
          pos_d = pos_q + 4'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      rlen_q   <= '0;
      tx_vld_q <= '0;
      rx_vld_q <= '0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      rlen_q   <= rlen_d;
      tx_vld_q <= tx_vld_d;
      rx_vld_q <= rx_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    plen_q <= plen_d;
    pos_q  <= pos_d;
    cmd_q  <= cmd_d;
    ack_q  <= ack_d;
    hit_q  <= hit_d;
  end

endmodule

FILE: src/i2c_slave_transfer_buffer_core.sv
// Top level of the I2C slave transfer buffer: sequencer, two RAMs, output register.
// Path: a bus reply goes through the reply state and the output register after its event,
// a message piece through the stop command state, a message state and the output register;
// output stalls hold either. New events stall until the sequencer is idle again; loads and
// length writes never leave idle; a stop streams one receive RAM entry a cycle unless stalled.
// Reset: asynchronous, clears index, reply length and valid bits; accepts events once released.
`timescale 1ns / 1ps

module i2c_slave_transfer_buffer_core #(
  parameter int unsigned RX_DEPTH = 16,
  parameter int unsigned TX_DEPTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  i2cstb_pkg::in_item_t  in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output i2cstb_pkg::out_item_t out_item_o
);
  import i2cstb_pkg::*;

  localparam int unsigned RX_WORDS = RX_DEPTH + 1;
  localparam int unsigned TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int unsigned RX_AW = (RX_WORDS > 1) ? $clog2(RX_WORDS) : 1;

  ram_req_t  tx_req;
  ram_req_t  rx_req;
  logic [7:0] tx_rdata;
  logic [7:0] rx_rdata;
  logic       res_valid;
  logic       res_stall;
  out_item_t  res;
  logic       out_valid_q;
  out_item_t  out_q;

  assign res_stall = out_valid_q && out_stall_i;

  i2cstb_seq #(
    .RX_DEPTH(RX_DEPTH),
    .TX_DEPTH(TX_DEPTH)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .res_valid_o(res_valid),
    .res_stall_i(res_stall),
    .res_o      (res),
    .tx_req_o   (tx_req),
    .tx_rdata_i (tx_rdata),
    .rx_req_o   (rx_req),
    .rx_rdata_i (rx_rdata)
  );

  i2cstb_ram #(
    .WIDTH(8),
    .DEPTH(TX_DEPTH)
  ) u_tx_ram (
    .clk_i  (clk_i),
    .we_i   (tx_req.we),
    .waddr_i(tx_req.waddr[TX_AW-1:0]),
    .wdata_i(tx_req.wdata),
    .re_i   (tx_req.re),
    .raddr_i(tx_req.raddr[TX_AW-1:0]),
    .rdata_o(tx_rdata)
  );

  i2cstb_ram #(
    .WIDTH(8),
    .DEPTH(RX_WORDS)
  ) u_rx_ram (
    .clk_i  (clk_i),
    .we_i   (rx_req.we),
    .waddr_i(rx_req.waddr[RX_AW-1:0]),
    .wdata_i(rx_req.wdata),
    .re_i   (rx_req.re),
    .raddr_i(rx_req.raddr[RX_AW-1:0]),
    .rdata_o(rx_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && !res_stall) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && !res_stall) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

FILE: src/i2cstb_chk.sv
// Port-level checker for the I2C slave transfer buffer, bound to the top level.
// Depends on i2cstb_pkg and i2c_slave_transfer_buffer_core.
`timescale 1ns / 1ps

module i2cstb_chk (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input i2cstb_pkg::in_item_t  in_item_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input i2cstb_pkg::out_item_t out_item_o
);
  import i2cstb_pkg::*;

  logic [7:0] in_seen;
  assign in_seen = {in_valid_i, in_stall_o, in_item_i.mode, 2'b00};

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result transfer changed");

  a_bus_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.kind == KIND_BUS) |->
      out_item_o.last && (out_item_o.command == 8'd0) &&
      (out_item_o.payload_length == 5'd0) && (out_item_o.payload_pos == 4'd0))
    else $error("bus reply carries message fields or is not last");

  a_msg_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.kind == KIND_MSG) |->
      ((out_item_o.payload_length == 5'd0) && out_item_o.last &&
       (out_item_o.payload_pos == 4'd0)) ||
      ({1'b0, out_item_o.payload_pos} < out_item_o.payload_length))
    else $error("message position outside its length");

  a_msg_run: assert property (@(posedge clk_i) disable iff (!rst_ni || (in_seen == 8'hFF))
    out_valid_o && !out_stall_i && (out_item_o.kind == KIND_MSG) && !out_item_o.last |=>
      !out_valid_o ||
      ((out_item_o.kind == KIND_MSG) && (out_item_o.command == $past(out_item_o.command)) &&
       (out_item_o.payload_pos == $past(out_item_o.payload_pos) + 4'd1)))
    else $error("message run broken");

endmodule

bind i2c_slave_transfer_buffer_core i2cstb_chk u_chk (.*);

FILE: dv/tb_top.sv
// Self-checking bench for i2c_slave_transfer_buffer_core: directed rows, then random bus
// transactions, with both sides idling and a long output hold-off to fill the block.
// Depends on i2cstb_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_top;
  import i2cstb_pkg::*;

  localparam int unsigned RX_D = 16;
  localparam int unsigned TX_D = 16;
  localparam int unsigned EVENT_TARGET = 360;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam logic [3:0] MODE_UNUSED_LO = 4'd9;
  localparam logic [3:0] MODE_UNUSED_HI = 4'd15;

  typedef struct {
    in_item_t  ev;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  logic [7:0] reply_mem [TX_D];
  logic [4:0] reply_len;
  logic [7:0] rx_mem [RX_D + 1];
  logic [5:0] shared_idx;

  out_item_t   awaited_results [$];
  dir_row_t    directed_rows [24];
  int unsigned events_sent;
  int unsigned results_taken;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned tx_run;
  int unsigned rx_run;
  bit          tx_calm;
  bit          rx_calm;

  i2c_slave_transfer_buffer_core #(
    .RX_DEPTH(RX_D),
    .TX_DEPTH(TX_D)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic out_item_t bus_reply(logic [7:0] rb, logic ack);
    out_item_t r;
    r = '0;
    r.kind = KIND_BUS;
    r.reply_byte = rb;
    r.ack_next = ack;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic out_item_t msg_piece(logic [7:0] cmd, logic [7:0] pb, logic [3:0] pos,
                                          logic [4:0] len, logic fin);
    out_item_t r;
    r = '0;
    r.kind = KIND_MSG;
    r.ack_next = 1'b1;
    r.command = cmd;
    r.payload_byte = pb;
    r.payload_pos = pos;
    r.payload_length = len;
    r.last = fin;
    return r;
  endfunction

  function automatic dir_row_t mk_row(logic [3:0] mode, logic [7:0] data, logic [3:0] slot,
                                      logic [4:0] len, bit typed, out_item_t want);
    dir_row_t row;
    row.ev.mode = mode;
    row.ev.data_byte = data;
    row.ev.load_slot = slot;
    row.ev.load_length = len;
    row.typed = typed;
    row.want = want;
    return row;
  endfunction

  function automatic in_item_t rand_event(logic [3:0] mode);
    in_item_t ev;
    ev.mode = mode;
    ev.data_byte = 8'($urandom);
    ev.load_slot = 4'($urandom);
    ev.load_length = 5'($urandom_range(0, 31));
    return ev;
  endfunction

  function automatic int unsigned pick_gap(inout int unsigned run_left, inout bit calm);
    if (run_left == 0) begin
      calm = ($urandom_range(0, 3) == 0);
      run_left = $urandom_range(10, 40);
    end
    run_left--;
    return calm ? 0 : $urandom_range(0, 15);
  endfunction

  task automatic bump_idx();
    if (shared_idx != INDEX_MAX) shared_idx++;
  endtask

  task automatic predict_results(in_item_t ev);
    int unsigned plen;
    logic [7:0] rb;
    case (ev.mode)
      MODE_READ_ADDR, MODE_REPLY_ACK: begin
        if (ev.mode == MODE_READ_ADDR) shared_idx = '0;
        rb = (shared_idx < TX_D) ? reply_mem[shared_idx[3:0]] : 8'h00;
        bump_idx();
        awaited_results.push_back(bus_reply(rb, shared_idx < reply_len));
      end
      MODE_WRITE_ADDR: begin
        shared_idx = '0;
        awaited_results.push_back(bus_reply(8'h00, RX_D != 0));
      end
      MODE_BYTE_RX: begin
        if (shared_idx < RX_D + 1) rx_mem[shared_idx] = ev.data_byte;
        bump_idx();
        awaited_results.push_back(bus_reply(8'h00, shared_idx < RX_D + 1));
      end
      MODE_STOP: begin
        if (shared_idx == 0) begin
          awaited_results.push_back(bus_reply(8'h00, 1'b1));
        end else begin
          plen = shared_idx - 1;
          if (plen > RX_D) plen = RX_D;
          if (plen > MSG_MAX) plen = MSG_MAX;
          if (plen == 0) begin
            awaited_results.push_back(msg_piece(rx_mem[0], 8'h00, 4'd0, 5'd0, 1'b1));
          end else begin
            for (int unsigned i = 0; i < plen; i++) begin
              awaited_results.push_back(msg_piece(rx_mem[0], rx_mem[i + 1], 4'(i),
                                                  5'(plen), i + 1 == plen));
            end
          end
        end
      end
      MODE_LOAD_BYTE: begin
        if (ev.load_slot < TX_D) reply_mem[ev.load_slot] = ev.data_byte;
      end
      MODE_SET_LEN: begin
        reply_len = (ev.load_length > TX_D) ? 5'(TX_D) : ev.load_length;
      end
      default: begin
        awaited_results.push_back(bus_reply(8'h00, 1'b1));
      end
    endcase
  endtask

  task automatic offer_event(in_item_t ev, bit typed, out_item_t want);
    int unsigned gap;
    gap = pick_gap(tx_run, tx_calm);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= ev;
    do @(posedge clk_i); while (in_stall_o);
    predict_results(ev);
    if (typed) awaited_results[awaited_results.size() - 1] = want;
    events_sent++;
    @(negedge clk_i);
  endtask

  function automatic bit field_ok(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin
    out_item_t want;
    bit good;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_taken++;
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual %p", $time, out_item_o);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        good = 1'b1;
        good &= field_ok("kind", want.kind, out_item_o.kind);
        good &= field_ok("reply_byte", want.reply_byte, out_item_o.reply_byte);
        good &= field_ok("ack_next", want.ack_next, out_item_o.ack_next);
        good &= field_ok("command", want.command, out_item_o.command);
        good &= field_ok("payload_byte", want.payload_byte, out_item_o.payload_byte);
        good &= field_ok("payload_pos", want.payload_pos, out_item_o.payload_pos);
        good &= field_ok("payload_length", want.payload_length, out_item_o.payload_length);
        good &= field_ok("last", want.last, out_item_o.last);
        if (!good) mismatches++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    int unsigned hold;
    bit held;
    out_stall_i = 1'b0;
    held = 1'b0;
    rx_run = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      hold = pick_gap(rx_run, rx_calm);
      if (!held && results_taken >= 30) begin
        held = 1'b1;
        hold += HOLD_CYCLES;
      end
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  initial begin
    int unsigned pick;
    int unsigned n;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    events_sent = 0;
    results_taken = 0;
    mismatches = 0;
    quiet_cycles = 0;
    tx_run = 0;
    reply_len = '0;
    shared_idx = '0;
    foreach (reply_mem[i]) reply_mem[i] = '0;
    foreach (rx_mem[i]) rx_mem[i] = '0;

    directed_rows[0]  = mk_row(MODE_READ_ADDR, 8'h00, 4'd0, 5'd0, 1, bus_reply(8'h00, 1'b0));
    directed_rows[1]  = mk_row(MODE_REPLY_ACK, 8'hFF, 4'd15, 5'd31, 1, bus_reply(8'h00, 1'b0));
    directed_rows[2]  = mk_row(MODE_STOP, 8'h00, 4'd0, 5'd0, 1,
                               msg_piece(8'h00, 8'h00, 4'd0, 5'd1, 1'b1));
    directed_rows[3]  = mk_row(MODE_WRITE_ADDR, 8'h00, 4'd0, 5'd0, 1, bus_reply(8'h00, 1'b1));
    directed_rows[4]  = mk_row(MODE_STOP, 8'h00, 4'd0, 5'd0, 1, bus_reply(8'h00, 1'b1));
    directed_rows[5]  = mk_row(MODE_LOAD_BYTE, 8'hFF, 4'd0, 5'd0, 0, '0);
    directed_rows[6]  = mk_row(MODE_LOAD_BYTE, 8'hA5, 4'd15, 5'd0, 0, '0);
    directed_rows[7]  = mk_row(MODE_SET_LEN, 8'h00, 4'd0, 5'd31, 0, '0);
    directed_rows[8]  = mk_row(MODE_READ_ADDR, 8'h00, 4'd0, 5'd0, 1, bus_reply(8'hFF, 1'b1));
    directed_rows[9]  = mk_row(MODE_REPLY_DONE, 8'hFF, 4'd15, 5'd31, 1,
                               bus_reply(8'h00, 1'b1));
    directed_rows[10] = mk_row(MODE_OTHER, 8'hFF, 4'd15, 5'd31, 1, bus_reply(8'h00, 1'b1));
    directed_rows[11] = mk_row(MODE_UNUSED_LO, 8'h00, 4'd0, 5'd0, 1, bus_reply(8'h00, 1'b1));
    directed_rows[12] = mk_row(MODE_UNUSED_HI, 8'hFF, 4'd15, 5'd31, 1,
                               bus_reply(8'h00, 1'b1));
    directed_rows[13] = mk_row(MODE_WRITE_ADDR, 8'h00, 4'd0, 5'd0, 0, '0);
    directed_rows[14] = mk_row(MODE_BYTE_RX, 8'hFF, 4'd0, 5'd0, 0, '0);
    directed_rows[15] = mk_row(MODE_STOP, 8'h00, 4'd0, 5'd0, 1,
                               msg_piece(8'hFF, 8'h00, 4'd0, 5'd0, 1'b1));
    directed_rows[16] = mk_row(MODE_WRITE_ADDR, 8'h00, 4'd0, 5'd0, 0, '0);
    directed_rows[17] = mk_row(MODE_BYTE_RX, 8'h00, 4'd0, 5'd0, 0, '0);
    directed_rows[18] = mk_row(MODE_BYTE_RX, 8'hFF, 4'd0, 5'd0, 0, '0);
    directed_rows[19] = mk_row(MODE_BYTE_RX, 8'h80, 4'd0, 5'd0, 0, '0);
    directed_rows[20] = mk_row(MODE_STOP, 8'h00, 4'd0, 5'd0, 0, '0);
    directed_rows[21] = mk_row(MODE_SET_LEN, 8'h00, 4'd0, 5'd0, 0, '0);
    directed_rows[22] = mk_row(MODE_READ_ADDR, 8'h00, 4'd0, 5'd0, 1, bus_reply(8'hFF, 1'b0));
    directed_rows[23] = mk_row(MODE_SET_LEN, 8'h00, 4'd0, 5'd16, 0, '0);

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      offer_event(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].want);
    end

    while (events_sent < EVENT_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 66) : $urandom_range(0, 18);
        offer_event(rand_event(MODE_WRITE_ADDR), 0, '0);
        repeat (n) offer_event(rand_event(MODE_BYTE_RX), 0, '0);
        // drop the stop now and then
        if ($urandom_range(0, 7) != 0) offer_event(rand_event(MODE_STOP), 0, '0);
      end else if (pick < 65) begin
        n = $urandom_range(0, 18);
        offer_event(rand_event(MODE_READ_ADDR), 0, '0);
        repeat (n) offer_event(rand_event(MODE_REPLY_ACK), 0, '0);
        offer_event(rand_event(MODE_REPLY_DONE), 0, '0);
        if ($urandom_range(0, 3) != 0) offer_event(rand_event(MODE_STOP), 0, '0);
      end else if (pick < 80) begin
        n = $urandom_range(1, 6);
        repeat (n) offer_event(rand_event(MODE_LOAD_BYTE), 0, '0);
        offer_event(rand_event(MODE_SET_LEN), 0, '0);
      end else begin
        n = $urandom_range(1, 3);
        repeat (n) offer_event(rand_event(4'($urandom_range(0, 15))), 0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
